// ===== rtl/ecmu_pkg.sv =====
// Shared types, constants and functions for the edge coverage map update block.
// No dependencies; every other file imports this package.
`default_nettype none
package ecmu_pkg;

  localparam int unsigned MAP_ENTRIES_DEF = 65536;
  localparam int unsigned MAX_NGRAM_DEF   = 16;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned HL_W   = 4;
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  localparam logic OP_HIT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] REG_HIST_LEN   = 2'd0;
  localparam logic [1:0] REG_NEVER_ZERO = 2'd1;
  localparam logic [1:0] REG_CTX_EN     = 2'd2;

  typedef struct packed {
    logic [HL_W-1:0] hist_len;
    logic            never_zero;
    logic            ctx_en;
  } cfg_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } map_ctl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_UPDATE
  } state_t;

  // reduce a 16-bit index modulo the map size (at least 256 entries)
  function automatic logic [ID_W-1:0] map_reduce(input logic [ID_W-1:0] v,
                                                 input int unsigned m);
    logic [31:0] r;
    logic [31:0] d;
    r = {16'b0, v};
    for (int k = 7; k >= 0; k--) begin
      d = 32'(m) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[ID_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ecmu_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on ecmu_pkg for cfg_t and register codes.
`default_nettype none
module ecmu_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ecmu_pkg::CFG_AW-1:0]  paddr,
  input  logic [ecmu_pkg::CFG_DW-1:0]  pwdata,
  output logic [ecmu_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output ecmu_pkg::cfg_t               cfg
);
  import ecmu_pkg::*;

  logic       wr;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hist_len   <= HL_W'(1);
      cfg.never_zero <= 1'b1;
      cfg.ctx_en     <= 1'b0;
    end else if (wr) begin
      unique case (reg_sel)
        REG_HIST_LEN:   cfg.hist_len   <= pwdata[HL_W-1:0];
        REG_NEVER_ZERO: cfg.never_zero <= pwdata[0];
        REG_CTX_EN:     cfg.ctx_en     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HIST_LEN:   prdata = CFG_DW'(cfg.hist_len);
      REG_NEVER_ZERO: prdata = CFG_DW'(cfg.never_zero);
      REG_CTX_EN:     prdata = CFG_DW'(cfg.ctx_en);
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/ecmu_hist.sv =====
// Block id history shift line and masked XOR reduction of its newest entries.
// Depends on ecmu_pkg for widths.
`default_nettype none
module ecmu_hist #(
  parameter int unsigned MAX_NGRAM = ecmu_pkg::MAX_NGRAM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [ecmu_pkg::ID_W-1:0]   push_id,
  input  logic [ecmu_pkg::HL_W-1:0]   hist_len,
  output logic [ecmu_pkg::ID_W-1:0]   hist_xor
);
  import ecmu_pkg::*;

  localparam int unsigned HD = MAX_NGRAM - 1;

  logic [ID_W-1:0] hist [HD];
  logic [HD-1:0]   sel;
  logic [HD-1:0]   col [ID_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(HD); i++) begin
        hist[i] <= '0;
      end
    end else if (push) begin
      hist[0] <= {1'b0, push_id[ID_W-1:1]};
      for (int i = 1; i < int'(HD); i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < int'(HD); i++) begin
      sel[i] = (i == 0) || (i < int'(hist_len));
    end
    for (int b = 0; b < int'(ID_W); b++) begin
      for (int i = 0; i < int'(HD); i++) begin
        col[b][i] = hist[i][b] & sel[i];
      end
      hist_xor[b] = ^col[b];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ecmu_map.sv =====
// Hit counter memory with one write and one registered read port, plus the
// clearing sweep after reset. Depends on ecmu_pkg for map_ctl_t and widths.
`default_nettype none
module ecmu_map #(
  parameter int unsigned MAP_ENTRIES = ecmu_pkg::MAP_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ecmu_pkg::map_ctl_t                 ctl,
  input  logic [$clog2(MAP_ENTRIES)-1:0]     rd_addr,
  input  logic [$clog2(MAP_ENTRIES)-1:0]     wr_addr,
  input  logic [ecmu_pkg::CNT_W-1:0]         wr_data,
  output logic [ecmu_pkg::CNT_W-1:0]         rd_data,
  output logic                               clearing
);
  import ecmu_pkg::*;

  localparam int unsigned AW = $clog2(MAP_ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(MAP_ENTRIES - 1);

  logic [CNT_W-1:0] mem [MAP_ENTRIES];
  logic [AW-1:0]    clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      if (clr_cnt == LAST) begin
        clearing <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/edge_coverage_map_update_top.sv =====
// Top level of the edge coverage map update block: sequencer and datapath.
// Depends on ecmu_pkg, ecmu_regs, ecmu_hist and ecmu_map.
//
//   channel   handshake                      payload
//   input     start / busy                   opcode, block_id, context_value, read_index
//   result    done (one-cycle strobe)        map_index, counter_value
//   config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// An item goes through index reduction and memory read in ST_INDEX, then read
// data update and write back in ST_UPDATE; a new item is taken in the write-back cycle.
// The result strobe is registered from the write-back state.
// After reset the map is swept to zero with busy high.
// The result side cannot stall.
`default_nettype none
module edge_coverage_map_update_top #(
  parameter int unsigned MAP_ENTRIES = ecmu_pkg::MAP_ENTRIES_DEF,
  parameter int unsigned MAX_NGRAM   = ecmu_pkg::MAX_NGRAM_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [ecmu_pkg::ID_W-1:0]     block_id,
  input  logic [ecmu_pkg::ID_W-1:0]     context_value,
  input  logic [ecmu_pkg::ID_W-1:0]     read_index,
  output logic                          done,
  output logic [ecmu_pkg::ID_W-1:0]     map_index,
  output logic [ecmu_pkg::CNT_W-1:0]    counter_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ecmu_pkg::CFG_AW-1:0]   paddr,
  input  logic [ecmu_pkg::CFG_DW-1:0]   pwdata,
  output logic [ecmu_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import ecmu_pkg::*;

  localparam int unsigned AW = $clog2(MAP_ENTRIES);

  cfg_t             cfg;
  state_t           state;
  state_t           state_next;
  map_ctl_t         ctl;
  logic             accept;
  logic             clearing;
  logic [ID_W-1:0]  hist_xor;
  logic             op_q;
  logic [ID_W-1:0]  raw_q;
  logic [ID_W-1:0]  idx_red;
  logic [ID_W-1:0]  idx_q;
  logic [CNT_W-1:0] rd_data;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_new;
  logic [CNT_W-1:0] result;

  ecmu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ecmu_hist #(.MAX_NGRAM(MAX_NGRAM)) u_hist (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && (opcode == OP_HIT)),
    .push_id  (block_id),
    .hist_len (cfg.hist_len),
    .hist_xor (hist_xor)
  );

  ecmu_map #(.MAP_ENTRIES(MAP_ENTRIES)) u_map (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_addr  (AW'(idx_red)),
    .wr_addr  (AW'(idx_q)),
    .wr_data  (cnt_new),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    unique case (state)
      ST_CLEAR:  state_next = clearing ? ST_CLEAR : ST_IDLE;
      ST_IDLE:   state_next = accept ? ST_INDEX : ST_IDLE;
      ST_INDEX:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = accept ? ST_INDEX : ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy      = (state == ST_CLEAR) || (state == ST_INDEX);
    ctl.rd_en = (state == ST_INDEX);
    ctl.wr_en = (state == ST_UPDATE) && (op_q == OP_HIT);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= opcode;
      if (opcode == OP_READ) begin
        raw_q <= read_index;
      end else begin
        raw_q <= block_id ^ hist_xor ^ (cfg.ctx_en ? context_value : '0);
      end
    end
    if (state == ST_INDEX) begin
      idx_q <= idx_red;
    end
  end

  assign idx_red = map_reduce(raw_q, MAP_ENTRIES);
  assign cnt_inc = rd_data + 1'b1;
  assign cnt_new = ((cnt_inc == '0) && cfg.never_zero) ? CNT_W'(1) : cnt_inc;
  assign result  = (op_q == OP_READ) ? rd_data : cnt_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      map_index     <= idx_q;
      counter_value <= result;
    end
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clearing |-> busy)
    else $error("item accepted during map clear");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("result strobe missing after accepted item");

  a_never_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && op_q == OP_HIT && cfg.never_zero) |=> (counter_value != '0))
    else $error("counter wrapped to zero with never_zero set");

endmodule
`default_nettype wire
